FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the equaliser RTL.
// Clocked on clk, disabled while arst_n is low; define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SBEQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SBEQ_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define SBEQ_ASSERT(label, prop, msg)
`define SBEQ_NEVER(label, cond, msg)
`endif
`endif

FILE: rtl/core/sbeq_pkg.sv
// Types, codes and default sizes for the stereo biquad equaliser.
// No dependencies; imported by stereo_biquad_eq_cascade_unit and the bench.
package sbeq_pkg;

	localparam int BAND_COUNT_DEF     = 10;
	localparam int CHANNEL_COUNT_DEF  = 2;
	localparam int SAMPLE_BITS_DEF    = 24;
	localparam int COEF_FRAC_BITS_DEF = 28;

	localparam int COEF_W         = 32;
	localparam int BAND_FIELD_W   = 4;
	localparam int SEL_W          = 3;
	localparam int COEFS_PER_BAND = 5;
	localparam int VOL_W          = 16;
	localparam int VOL_FRAC       = 15;
	localparam int APB_DATA_W     = 32;
	localparam int APB_ADDR_W     = 3;

	localparam logic [VOL_W-1:0] VOL_UNITY = 16'h8000;

	typedef logic [SEL_W-1:0] coef_sel_t;

	localparam coef_sel_t SEL_B0     = 3'd0;
	localparam coef_sel_t SEL_B1     = 3'd1;
	localparam coef_sel_t SEL_B2     = 3'd2;
	localparam coef_sel_t SEL_A1     = 3'd3;
	localparam coef_sel_t SEL_A2     = 3'd4;
	localparam coef_sel_t SEL_ACTIVE = 3'd5;

	localparam logic OP_COEF_WRITE = 1'b0;
	localparam logic OP_SAMPLE     = 1'b1;

	localparam logic REG_EQ_ENABLE = 1'b0;
	localparam logic REG_VOLUME    = 1'b1;

endpackage

FILE: rtl/core/stereo_biquad_eq_cascade_unit.sv
// Stereo parametric equaliser: biquad band cascade, volume and saturation.
// Depends on sbeq_pkg and assert_macros.svh.
//
// Use: beats on the slave stream carry either a coefficient write (tuser low) or a
// sample (tuser high). A write updates one coefficient or band active bit in the
// beat's own cycle and gives no result; the slave side is ready again at once.
// A sample runs through every active band, one direct-form-I biquad per band with
// history per channel, then through the volume stage; one result beat follows.
// A single 32 x SAMPLE_BITS multiplier and one accumulator serve all five taps of
// every band and the volume product, stepped by the state sequencer; coefficients
// and histories sit in one-read one-write memories with registered read data.
// With the equaliser disabled or for an unused channel a sample skips the bands and goes
// straight to the volume stage. The slave side is ready again in the cycle in which
// the result beat becomes valid. The result waits in an output register, so the next
// sample is accepted while it is pending; a sample that finishes before the register
// drains holds in place.
// The APB port sets eq_enable (0x0) and volume_gain (0x4); pready is always high.
// Reset clears the valid bits of both memories: coefficients read back as b0 = 1.0
// and the rest zero, all histories as zero, every band inactive. No clearing pass.
module stereo_biquad_eq_cascade_unit #(
	parameter int BAND_COUNT     = sbeq_pkg::BAND_COUNT_DEF,
	parameter int CHANNEL_COUNT  = sbeq_pkg::CHANNEL_COUNT_DEF,
	parameter int SAMPLE_BITS    = sbeq_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = sbeq_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// band_index[3:0], coef_select[6:4], coef_value[38:7], channel[39], sample_in above
	input  logic [((40 + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// operation
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// sample_out[SAMPLE_BITS-1:0], channel_out[SAMPLE_BITS]
	output logic [((SAMPLE_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [sbeq_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sbeq_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sbeq_pkg::APB_DATA_W-1:0] prdata,
	output logic pready
);
	import sbeq_pkg::*;

	localparam int SB        = SAMPLE_BITS;
	localparam int M_TDATA_W = ((SB + 1 + 7) / 8) * 8;
	localparam int CROWS     = BAND_COUNT * COEFS_PER_BAND;
	localparam int CADDR_W   = $clog2(CROWS);
	localparam int HROWS     = BAND_COUNT * CHANNEL_COUNT;
	localparam int HROW_W    = (HROWS > 1) ? $clog2(HROWS) : 1;
	localparam int BAND_IW   = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
	localparam int BAND_CW   = $clog2(BAND_COUNT + 1);
	localparam int CH_IW     = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int PROD_W    = COEF_W + SB;
	localparam int ACC_W     = PROD_W + 3;

	localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;
	localparam logic signed [ACC_W-1:0] BAND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] VOL_HALF  = ACC_W'(1) << (VOL_FRAC - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI    =
		$signed((ACC_W'(1) << (SB - 1)) - ACC_W'(1));
	localparam logic signed [ACC_W-1:0] SAT_LO    = -SAT_HI - ACC_W'(1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_MAC   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;
	localparam logic [2:0] ST_VOL   = 3'd5;
	localparam logic [2:0] ST_VACC  = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	// input fields
	logic [BAND_FIELD_W-1:0] in_band;
	coef_sel_t               in_sel;
	logic [COEF_W-1:0]       in_coef;
	logic                    in_chan;
	logic signed [SB-1:0]    in_sample;

	assign in_band   = s_tdata[3:0];
	assign in_sel    = s_tdata[6:4];
	assign in_coef   = s_tdata[38:7];
	assign in_chan   = s_tdata[39];
	assign in_sample = s_tdata[40 +: SB];

	// configuration
	logic             eq_enable_q;
	logic [VOL_W-1:0] volume_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eq_enable_q <= 1'b0;
			volume_q    <= VOL_UNITY;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_EQ_ENABLE: eq_enable_q <= pwdata[0];
				REG_VOLUME:    volume_q    <= pwdata[VOL_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_EQ_ENABLE: prdata = APB_DATA_W'(eq_enable_q);
			REG_VOLUME:    prdata = APB_DATA_W'(volume_q);
			default:       prdata = '0;
		endcase
	end

	// sequencer state
	logic [2:0]           state_q;
	logic [BAND_CW-1:0]   band_q;
	coef_sel_t            k_q;
	logic                 chan_q;
	logic signed [SB-1:0] x_q;
	logic signed [ACC_W-1:0] acc_q;

	logic             in_acc;
	logic             band_ok;
	logic             chan_ok;
	logic [BAND_IW-1:0] band_idx;
	logic [BAND_IW-1:0] wband_idx;
	logic [CH_IW-1:0]   chan_idx;
	logic [CADDR_W-1:0] coef_raddr;
	logic [CADDR_W-1:0] coef_waddr;
	logic [HROW_W-1:0]  hrow;
	logic               coef_we;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid & s_tready;
	assign band_ok   = int'(in_band) < BAND_COUNT;
	assign chan_ok   = int'(in_chan) < CHANNEL_COUNT;
	assign band_idx  = band_q[BAND_IW-1:0];
	assign wband_idx = BAND_IW'(in_band);
	assign chan_idx  = CH_IW'(chan_q);
	assign coef_raddr = CADDR_W'(int'(band_idx) * COEFS_PER_BAND + int'(k_q));
	assign coef_waddr = CADDR_W'(int'(wband_idx) * COEFS_PER_BAND + int'(in_sel));
	assign hrow       = HROW_W'(int'(band_idx) * CHANNEL_COUNT + int'(chan_idx));
	assign coef_we    = in_acc && s_tuser == OP_COEF_WRITE && band_ok &&
		in_sel < SEL_ACTIVE;

	// coefficient memory with valid bits
	logic [COEF_W-1:0]     coef_mem [CROWS];
	logic [CROWS-1:0]      coef_vld_q;
	logic [BAND_COUNT-1:0] band_active_q;
	logic [COEF_W-1:0]     coef_rd_s1;
	logic                  coef_vld_s1;

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_waddr] <= in_coef;
		end
		coef_rd_s1 <= coef_mem[coef_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q    <= '0;
			band_active_q <= '0;
			coef_vld_s1   <= 1'b0;
		end else begin
			coef_vld_s1 <= coef_vld_q[coef_raddr];
			if (coef_we) begin
				coef_vld_q[coef_waddr] <= 1'b1;
			end
			if (in_acc && s_tuser == OP_COEF_WRITE && band_ok && in_sel == SEL_ACTIVE) begin
				band_active_q[wband_idx] <= (in_coef != '0);
			end
		end
	end

	// history memory: one row per band and channel, {y2, y1, x2, x1}
	logic [4*SB-1:0]      hist_mem [HROWS];
	logic [HROWS-1:0]     hist_vld_q;
	logic [4*SB-1:0]      hist_rd_q;
	logic                 hist_rd_vld_q;
	logic [4*SB-1:0]      hist_eff;
	logic signed [SB-1:0] h_x1;
	logic signed [SB-1:0] h_x2;
	logic signed [SB-1:0] h_y1;
	logic signed [SB-1:0] h_y2;
	logic                 hist_we;
	logic signed [SB-1:0] y_sat;

	assign hist_eff = hist_rd_vld_q ? hist_rd_q : '0;
	assign h_x1     = hist_eff[0 +: SB];
	assign h_x2     = hist_eff[SB +: SB];
	assign h_y1     = hist_eff[2*SB +: SB];
	assign h_y2     = hist_eff[3*SB +: SB];
	assign hist_we  = (state_q == ST_FIN);

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hrow] <= {h_y1, y_sat, h_x1, x_q};
		end
		hist_rd_q <= hist_mem[hrow];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q    <= '0;
			hist_rd_vld_q <= 1'b0;
		end else begin
			hist_rd_vld_q <= hist_vld_q[hrow];
			if (hist_we) begin
				hist_vld_q[hrow] <= 1'b1;
			end
		end
	end

	// shared multiplier and accumulator
	logic                     s1_vld_q;
	coef_sel_t                k_s1;
	logic                     s2_vld_q;
	logic                     neg_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [COEF_W-1:0] coef_eff;
	logic signed [SB-1:0]     opnd;
	logic signed [COEF_W-1:0] mul_a;
	logic signed [SB-1:0]     mul_b;
	logic [VOL_W-1:0]         gain;
	logic                     vol_phase;

	assign gain      = (volume_q > VOL_UNITY) ? VOL_UNITY : volume_q;
	assign vol_phase = (state_q == ST_VOL);

	always_comb begin
		if (coef_vld_s1) begin
			coef_eff = $signed(coef_rd_s1);
		end else begin
			coef_eff = (k_s1 == SEL_B0) ? COEF_ONE : '0;
		end
		unique case (k_s1)
			SEL_B0:  opnd = x_q;
			SEL_B1:  opnd = h_x1;
			SEL_B2:  opnd = h_x2;
			SEL_A1:  opnd = h_y1;
			SEL_A2:  opnd = h_y2;
			default: opnd = '0;
		endcase
		mul_a = vol_phase ? $signed({{(COEF_W - VOL_W){1'b0}}, gain}) : coef_eff;
		mul_b = vol_phase ? x_q : opnd;
	end

	always_ff @(posedge clk) begin
		k_s1    <= k_q;
		neg_s2  <= s1_vld_q && (k_s1 == SEL_A1 || k_s1 == SEL_A2);
		prod_s2 <= mul_a * mul_b;
	end

	// rounding shift and saturation
	logic signed [ACC_W-1:0] shifted;

	always_comb begin
		shifted = (state_q == ST_OUT) ? (acc_q >>> VOL_FRAC) : (acc_q >>> COEF_FRAC_BITS);
		if (shifted > SAT_HI) begin
			y_sat = SAT_HI[SB-1:0];
		end else if (shifted < SAT_LO) begin
			y_sat = SAT_LO[SB-1:0];
		end else begin
			y_sat = shifted[SB-1:0];
		end
	end

	// output register
	logic                 m_tvalid_q;
	logic signed [SB-1:0] sample_out_q;
	logic                 chan_out_q;
	logic                 out_load;

	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'({chan_out_q, sample_out_q});

	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_out_q <= y_sat;
			chan_out_q   <= chan_q;
		end
	end

	// sequencer
	logic                    band_active_cur;
	logic [2:0]              state_d;

	assign band_active_cur = band_active_q[band_idx];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && s_tuser == OP_SAMPLE) begin
					state_d = (eq_enable_q && chan_ok) ? ST_SCAN : ST_VOL;
				end
			end
			ST_SCAN: begin
				if (band_q == BAND_CW'(BAND_COUNT)) begin
					state_d = ST_VOL;
				end else if (band_active_cur) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				if (k_q == SEL_A2) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!s1_vld_q && !s2_vld_q) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN:  state_d = ST_SCAN;
			ST_VOL:  state_d = ST_VACC;
			ST_VACC: state_d = ST_OUT;
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			band_q     <= '0;
			k_q        <= SEL_B0;
			s1_vld_q   <= 1'b0;
			s2_vld_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			s1_vld_q <= (state_q == ST_MAC);
			s2_vld_q <= s1_vld_q || vol_phase;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			priority if (state_q == ST_IDLE) begin
				band_q <= '0;
			end else if (state_q == ST_SCAN && band_q != BAND_CW'(BAND_COUNT) &&
				!band_active_cur) begin
				band_q <= band_q + BAND_CW'(1);
			end else if (state_q == ST_FIN) begin
				band_q <= band_q + BAND_CW'(1);
			end
			if (state_q == ST_MAC) begin
				k_q <= k_q + coef_sel_t'(1);
			end else begin
				k_q <= SEL_B0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == OP_SAMPLE) begin
			x_q    <= in_sample;
			chan_q <= in_chan;
		end else if (state_q == ST_FIN) begin
			x_q <= y_sat;
		end
		priority if (state_q == ST_SCAN) begin
			acc_q <= BAND_HALF;
		end else if (vol_phase) begin
			acc_q <= VOL_HALF;
		end else if (s2_vld_q) begin
			acc_q <= neg_s2 ? acc_q - ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		end
	end

`include "assert_macros.svh"

	`SBEQ_ASSERT(a_sample_busy, in_acc && s_tuser == OP_SAMPLE |=> !s_tready, "sample accepted but still ready")
	`SBEQ_ASSERT(a_out_loads, out_load |=> m_tvalid && s_tready, "result register not loaded on finish")
	`SBEQ_NEVER(a_fin_drained, state_q == ST_FIN && (s1_vld_q || s2_vld_q), "history written before taps drained")
	`SBEQ_NEVER(a_band_range, band_q > BAND_CW'(BAND_COUNT), "band counter past last band")

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for stereo_biquad_eq_cascade_unit: drives sample and coefficient beats and APB writes.
// A bit-exact model of the band cascade and volume stage predicts each result beat.
// Depends on sbeq_pkg and the unit's RTL only.
module tb;
	import sbeq_pkg::*;

	localparam int IN_W = ((40 + SAMPLE_BITS_DEF + 7) / 8) * 8;
	localparam int OUT_W = ((SAMPLE_BITS_DEF + 1 + 7) / 8) * 8;
	localparam int RUN_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 120;
	localparam int HOLD_CYCLES = 600;
	localparam int PHASE_ITEMS = 250;
	localparam int PHASE_COUNT = 6;
	localparam int Q_ONE = 1 << COEF_FRAC_BITS_DEF;

	typedef struct packed {
		logic [SAMPLE_BITS_DEF-1:0] smp;
		logic ch;
	} due_t;

	class eq_tracker;
		logic signed [COEF_W-1:0] coef [BAND_COUNT_DEF][COEFS_PER_BAND];
		bit band_on [BAND_COUNT_DEF];
		longint x_d1 [BAND_COUNT_DEF][CHANNEL_COUNT_DEF];
		longint x_d2 [BAND_COUNT_DEF][CHANNEL_COUNT_DEF];
		longint y_d1 [BAND_COUNT_DEF][CHANNEL_COUNT_DEF];
		longint y_d2 [BAND_COUNT_DEF][CHANNEL_COUNT_DEF];
		bit eq_on;
		logic [VOL_W-1:0] gain;
		due_t due [$];
		int mismatches;
		int samples_in;
		int writes_in;
		int results_out;

		function new();
			for (int b = 0; b < BAND_COUNT_DEF; b++) begin
				for (int k = 0; k < COEFS_PER_BAND; k++)
					coef[b][k] = (k == SEL_B0) ? Q_ONE : 0;
				band_on[b] = 1'b0;
				for (int c = 0; c < CHANNEL_COUNT_DEF; c++) begin
					x_d1[b][c] = 0;
					x_d2[b][c] = 0;
					y_d1[b][c] = 0;
					y_d2[b][c] = 0;
				end
			end
			eq_on = 1'b0;
			gain = VOL_UNITY;
			mismatches = 0;
			samples_in = 0;
			writes_in = 0;
			results_out = 0;
		endfunction

		function longint clamp_audio(longint v);
			longint top;
			top = (longint'(1) <<< (SAMPLE_BITS_DEF - 1)) - 1;
			if (v > top)
				return top;
			if (v < -top - 1)
				return -top - 1;
			return v;
		endfunction

		function longint run_section(int b, int c, longint x0);
			longint acc;
			longint y0;
			acc = longint'(coef[b][SEL_B0]) * x0 + longint'(coef[b][SEL_B1]) * x_d1[b][c]
				+ longint'(coef[b][SEL_B2]) * x_d2[b][c] - longint'(coef[b][SEL_A1]) * y_d1[b][c]
				- longint'(coef[b][SEL_A2]) * y_d2[b][c];
			y0 = clamp_audio((acc + (longint'(1) <<< (COEF_FRAC_BITS_DEF - 1)))
				>>> COEF_FRAC_BITS_DEF);
			x_d2[b][c] = x_d1[b][c];
			x_d1[b][c] = x0;
			y_d2[b][c] = y_d1[b][c];
			y_d1[b][c] = y0;
			return y0;
		endfunction

		function void set_register(logic idx, logic [APB_DATA_W-1:0] val);
			if (idx == REG_EQ_ENABLE)
				eq_on = val[0];
			else
				gain = val[VOL_W-1:0];
		endfunction

		function void note_beat(logic op, logic [IN_W-1:0] d);
			logic [BAND_FIELD_W-1:0] band;
			coef_sel_t sel;
			logic signed [COEF_W-1:0] val;
			logic ch;
			logic signed [SAMPLE_BITS_DEF-1:0] smp;
			longint s;
			longint g;
			due_t e;
			band = d[3:0];
			sel = d[6:4];
			val = d[38:7];
			ch = d[39];
			smp = d[40 +: SAMPLE_BITS_DEF];
			if (op == OP_COEF_WRITE) begin
				writes_in++;
				if (band < BAND_COUNT_DEF) begin
					if (sel < COEFS_PER_BAND)
						coef[band][sel] = val;
					else if (sel == SEL_ACTIVE)
						band_on[band] = (val != 0);
				end
				return;
			end
			samples_in++;
			s = smp;
			g = (gain > VOL_UNITY) ? longint'(VOL_UNITY) : longint'(gain);
			if (eq_on && ch < CHANNEL_COUNT_DEF) begin
				for (int b = 0; b < BAND_COUNT_DEF; b++)
					if (band_on[b])
						s = run_section(b, ch, s);
			end
			s = clamp_audio((s * g + 16384) >>> VOL_FRAC);
			e.smp = s[SAMPLE_BITS_DEF-1:0];
			e.ch = ch;
			due.push_back(e);
		endfunction

		task report(string what);
			mismatches++;
			$display("mismatch at %0t: %s", $realtime, what);
		endtask

		task check_result(logic [OUT_W-1:0] d);
			due_t e;
			results_out++;
			if (due.size() == 0) begin
				report($sformatf("result beat %h with nothing due", d));
				return;
			end
			e = due.pop_front();
			if (d[SAMPLE_BITS_DEF-1:0] !== e.smp)
				report($sformatf("sample_out %h, want %h", d[SAMPLE_BITS_DEF-1:0], e.smp));
			if (d[SAMPLE_BITS_DEF] !== e.ch)
				report($sformatf("channel_out %b, want %b", d[SAMPLE_BITS_DEF], e.ch));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	// band_index, coef_select, coef_value, channel, sample_in
	logic [IN_W-1:0] s_tdata;
	// operation
	logic s_tuser;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// sample_out, channel_out
	logic [OUT_W-1:0] m_tdata;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	eq_tracker tracker;
	int cycle_count = 0;
	int send_idle_pct = 24;
	int recv_idle_pct = 65;
	logic hold_trigger = 1'b0;
	logic hold_seen = 1'b0;
	int hold_left = 0;

	stereo_biquad_eq_cascade_unit dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (m_tvalid && m_tready)
				tracker.check_result(m_tdata);
			if (s_tvalid && s_tready)
				tracker.note_beat(s_tuser, s_tdata);
		end
	end

	// hold off the output for a long stretch when asked, else stall at random
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_trigger != hold_seen) begin
			hold_seen <= hold_trigger;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic logic [IN_W-1:0] pack_beat(logic [BAND_FIELD_W-1:0] band, coef_sel_t sel,
		logic [COEF_W-1:0] val, logic ch, logic [SAMPLE_BITS_DEF-1:0] smp);
		return {smp, ch, val, sel, band};
	endfunction

	function automatic logic [COEF_W-1:0] random_coef(coef_sel_t sel);
		if ($urandom_range(9) == 0)
			return $urandom;
		if (sel == SEL_A1 || sel == SEL_A2)
			return $urandom_range(Q_ONE) - Q_ONE / 2;
		return $urandom_range(2 * Q_ONE) - Q_ONE;
	endfunction

	function automatic logic [SAMPLE_BITS_DEF-1:0] random_audio();
		case ($urandom_range(9))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2, 3: return $urandom_range(8191) - 4096;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_beat(logic op, logic [IN_W-1:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_write(logic [BAND_FIELD_W-1:0] band, coef_sel_t sel,
		logic [COEF_W-1:0] val);
		send_beat(OP_COEF_WRITE, pack_beat(band, sel, val, $urandom_range(1), $urandom));
	endtask

	task automatic send_audio(logic ch, logic [SAMPLE_BITS_DEF-1:0] smp);
		send_beat(OP_SAMPLE, pack_beat($urandom_range(15), $urandom_range(7), $urandom, ch, smp));
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (tracker.due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(logic idx, logic [APB_DATA_W-1:0] val);
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_register(idx, val);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		int n;
		int pick;
		int band;
		logic [APB_DATA_W-1:0] phase_gain [PHASE_COUNT];
		logic phase_enable [PHASE_COUNT];
		tracker = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= 1'b0;
		s_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		phase_gain = '{32768, 20000, 65535, 1, $urandom_range(65535), 32767};
		phase_enable = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bypass at reset, then full-scale coefficients through one band
		send_audio(1'b0, 24'h7FFFFF);
		send_audio(1'b1, 24'h800000);
		apb_write(REG_EQ_ENABLE, 1);
		send_audio(1'b0, 24'h400000);
		send_write(4'd0, SEL_B0, 32'h7FFFFFFF);
		send_write(4'd0, SEL_B1, 32'h80000000);
		send_write(4'd0, SEL_ACTIVE, 32'h80000000);
		send_audio(1'b0, 24'h7FFFFF);
		send_audio(1'b0, 24'h800000);
		send_audio(1'b1, 24'h123456);
		send_write(4'd15, SEL_B0, 32'h0);
		send_write(4'd10, SEL_ACTIVE, 32'h1);
		send_write(4'd0, 3'd6, 32'h0);
		send_write(4'd0, 3'd7, 32'h0);
		send_write(4'd0, SEL_A1, Q_ONE / 2);
		send_write(4'd0, SEL_A2, -(Q_ONE / 4));
		send_write(4'd0, SEL_B2, Q_ONE / 2);
		send_write(4'd9, SEL_ACTIVE, 32'h1);
		send_audio(1'b0, 24'h000000);
		send_audio(1'b1, 24'hFFFFFF);
		send_write(4'd0, SEL_ACTIVE, 32'h0);
		send_audio(1'b0, 24'h2AAAAA);
		apb_write(REG_VOLUME, 0);
		send_audio(1'b1, 24'h7FFFFF);
		apb_write(REG_VOLUME, 65535);
		send_audio(1'b0, 24'h800000);
		apb_write(REG_EQ_ENABLE, 0);
		send_audio(1'b1, 24'h555555);

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			apb_write(REG_EQ_ENABLE, phase_enable[phase]);
			apb_write(REG_VOLUME, phase_gain[phase]);
			if (phase == 2) begin
				send_idle_pct = 65;
				recv_idle_pct <= 24;
				hold_trigger <= ~hold_trigger;
			end else if (phase == 4) begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
			end
			n = 0;
			while (n < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 5) begin
					// program one whole band, then arm or clear it
					band = $urandom_range(BAND_COUNT_DEF - 1);
					for (int k = 0; k < COEFS_PER_BAND; k++)
						send_write(band, k, random_coef(k));
					send_write(band, SEL_ACTIVE, $urandom_range(3) == 0 ? 32'h0 :
						($urandom_range(1) ? 32'h1 : ($urandom | 32'h1)));
					n += COEFS_PER_BAND + 1;
				end else if (pick < 13) begin
					band = $urandom_range(15);
					pick = $urandom_range(7);
					send_write(band, pick, $urandom);
					if (band < BAND_COUNT_DEF && pick <= SEL_ACTIVE)
						n++;
				end else begin
					send_audio($urandom_range(1), random_audio());
					n++;
				end
			end
		end

		settle();
		$display("run covered %0d sample beats and %0d coefficient writes, %0d results checked",
			tracker.samples_in, tracker.writes_in, tracker.results_out);
		$display("with the cascade on and bypassed, volume 0 to 65535, and a long output stall");
		if (tracker.mismatches == 0 && tracker.due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

FILE: stereo_biquad_eq_cascade_unit.f
+incdir+rtl/core
rtl/core/sbeq_pkg.sv
rtl/core/stereo_biquad_eq_cascade_unit.sv
bench/tb.sv
